### rtl/value_set_table_macros.svh
// Assertion macros used by the value set table checker
`ifndef VALUE_SET_TABLE_MACROS_SVH
`define VALUE_SET_TABLE_MACROS_SVH

// check that a property holds on every rising clock edge outside reset
`define VST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition never holds outside reset
`define VST_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/vst_pkg.sv
// Types and constants of the value set table
`timescale 1ns / 1ps

package vst_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 22;
    localparam int VALUE_IN_W     = 22;
    localparam int KEY_EXT_W      = 32;
    localparam int COUNT_OUT_W    = 7;
    localparam int CMD_W          = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CHECK  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
        t_cmd cmd;
    } t_req;

    typedef struct packed {
        logic done;
        logic found;
        logic changed;
        logic full_drop;
    } t_rsp;

endpackage

### rtl/vst_ram.sv
// Generic single write port RAM with registered read
`timescale 1ns / 1ps

module vst_ram #(
    parameter int WIDTH = vst_pkg::VALUE_BITS_DEF,
    parameter int DEPTH = vst_pkg::CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/vst_engine.sv
// Scan, append and compaction sequencer around the entry store
`timescale 1ns / 1ps

module vst_engine #(
    parameter int CAPACITY   = vst_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = vst_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vst_pkg::t_req                 i_req,
    input  logic [VALUE_BITS-1:0]         i_key,
    input  logic                          i_slot_free,
    output vst_pkg::t_rsp                 o_rsp,
    output logic [$clog2(CAPACITY+1)-1:0] o_count
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    vst_pkg::t_state       r_state, n_state;
    vst_pkg::t_cmd         r_cmd;
    logic [VALUE_BITS-1:0] r_key;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_issue, n_issue;
    logic [CNT_W-1:0]      r_cmp_pos, n_cmp_pos;
    logic [CNT_W-1:0]      r_wr, n_wr;
    logic                  r_rd_vld, n_rd_vld;
    logic                  r_found, n_found;
    logic                  r_changed, n_changed;
    logic                  r_drop, n_drop;

    logic                  w_we;
    logic [ADDR_W-1:0]     w_waddr;
    logic [VALUE_BITS-1:0] w_wdata;
    logic [VALUE_BITS-1:0] w_rdata;
    logic                  w_hit;
    logic                  w_done;

    vst_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_issue[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= vst_pkg::ST_IDLE;
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_changed <= 1'b0;
            r_drop    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_vld  <= n_rd_vld;
            r_found   <= n_found;
            r_changed <= n_changed;
            r_drop    <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_issue   <= n_issue;
        r_cmp_pos <= n_cmp_pos;
        r_wr      <= n_wr;
        if (i_req.start) begin
            r_cmd <= i_req.cmd;
            r_key <= i_key;
        end
    end

    assign w_hit = r_rd_vld && (w_rdata == r_key);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_issue   = r_issue;
        n_cmp_pos = r_cmp_pos;
        n_wr      = r_wr;
        n_rd_vld  = 1'b0;
        n_found   = r_found;
        n_changed = r_changed;
        n_drop    = r_drop;
        w_we      = 1'b0;
        w_waddr   = r_wr[ADDR_W-1:0];
        w_wdata   = w_rdata;
        w_done    = 1'b0;
        unique case (r_state)
            vst_pkg::ST_IDLE: begin
                if (i_req.start) begin
                    n_state   = vst_pkg::ST_SCAN;
                    n_issue   = '0;
                    n_found   = 1'b0;
                    n_changed = 1'b0;
                    n_drop    = 1'b0;
                end
            end
            vst_pkg::ST_SCAN: begin
                if (w_hit) begin
                    n_found = 1'b1;
                    if (r_cmd == vst_pkg::CMD_REMOVE) begin
                        n_issue   = CNT_W'(r_cmp_pos + 1'b1);
                        n_wr      = r_cmp_pos;
                        n_changed = 1'b1;
                        n_state   = vst_pkg::ST_SHIFT;
                    end else begin
                        n_state = vst_pkg::ST_DONE;
                    end
                end else if (!r_rd_vld && (r_issue >= r_count)) begin
                    if (r_cmd == vst_pkg::CMD_ADD) begin
                        if (r_count < CNT_W'(CAPACITY)) begin
                            w_we      = 1'b1;
                            w_waddr   = r_count[ADDR_W-1:0];
                            w_wdata   = r_key;
                            n_count   = CNT_W'(r_count + 1'b1);
                            n_changed = 1'b1;
                        end else begin
                            n_drop = 1'b1;
                        end
                    end
                    n_state = vst_pkg::ST_DONE;
                end else if (r_issue < r_count) begin
                    n_issue   = CNT_W'(r_issue + 1'b1);
                    n_cmp_pos = r_issue;
                    n_rd_vld  = 1'b1;
                end
            end
            vst_pkg::ST_SHIFT: begin
                if (r_rd_vld) begin
                    w_we = 1'b1;
                    n_wr = CNT_W'(r_wr + 1'b1);
                end
                if (r_issue < r_count) begin
                    n_issue  = CNT_W'(r_issue + 1'b1);
                    n_rd_vld = 1'b1;
                end else if (!r_rd_vld) begin
                    n_count = CNT_W'(r_count - 1'b1);
                    n_state = vst_pkg::ST_DONE;
                end
            end
            vst_pkg::ST_DONE: begin
                if (i_slot_free) begin
                    w_done  = 1'b1;
                    n_state = vst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = vst_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_rsp.done      = w_done;
    assign o_rsp.found     = r_found;
    assign o_rsp.changed   = r_changed;
    assign o_rsp.full_drop = r_drop;
    assign o_count         = r_count;

endmodule

### rtl/value_set_table.sv
// Top level of the value set table: handshakes, key masking, result register
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------------
//  request  | in        | i_valid / o_ready  | i_command, i_value
//  result   | out       | o_valid / i_ready  | o_found, o_changed, o_full_drop,
//           |           |                    | o_entry_count
//
// With N stored entries, a check or add scans up to N entries before its result
// and a remove then compacts the store: the scan reads one entry per cycle
// through the single read port of the entry store, and a remove then moves each
// later entry down one place per cycle. o_ready returns in the same cycle as the
// result. Reset clears the entry count and the control state; the store holds no
// reset state. A result waiting in the output register does not block the next
// request; it stalls only the finish of that next request.
`timescale 1ns / 1ps

module value_set_table #(
    parameter int CAPACITY   = vst_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = vst_pkg::VALUE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [vst_pkg::CMD_W-1:0]       i_command,
    input  logic [vst_pkg::VALUE_IN_W-1:0]  i_value,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_found,
    output logic                            o_changed,
    output logic                            o_full_drop,
    output logic [vst_pkg::COUNT_OUT_W-1:0] o_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                          r_busy;
    vst_pkg::t_req                 w_req;
    vst_pkg::t_rsp                 w_rsp;
    logic [vst_pkg::KEY_EXT_W-1:0] w_value_ext;
    logic [CNT_W-1:0]              w_count;
    logic                          w_slot_free;

    assign o_ready     = !r_busy;
    assign w_req.start = i_valid && o_ready;
    assign w_req.cmd   = vst_pkg::t_cmd'(i_command);
    assign w_value_ext = vst_pkg::KEY_EXT_W'(i_value);
    assign w_slot_free = !o_valid || i_ready;

    vst_engine #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_key       (w_value_ext[VALUE_BITS-1:0]),
        .i_slot_free (w_slot_free),
        .o_rsp       (w_rsp),
        .o_count     (w_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (w_req.start) begin
                r_busy <= 1'b1;
            end else if (w_rsp.done) begin
                r_busy <= 1'b0;
            end
            if (w_rsp.done) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rsp.done) begin
            o_found       <= w_rsp.found;
            o_changed     <= w_rsp.changed;
            o_full_drop   <= w_rsp.full_drop;
            o_entry_count <= vst_pkg::COUNT_OUT_W'(w_count);
        end
    end

endmodule

### rtl/vst_checker.sv
// Port-level assertions for the value set table and their bind
`timescale 1ns / 1ps
`include "value_set_table_macros.svh"

module vst_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic [vst_pkg::CMD_W-1:0]       i_command,
    input logic [vst_pkg::VALUE_IN_W-1:0]  i_value,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic                            o_found,
    input logic                            o_changed,
    input logic                            o_full_drop,
    input logic [vst_pkg::COUNT_OUT_W-1:0] o_entry_count
);

    logic w_unused;
    assign w_unused = ^{i_command, i_value};

    `VST_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_valid && o_ready) |=> !o_ready, "request accepted while a transaction is in progress")
    `VST_ASSERT(a_result_after_work, i_clk, i_rst_n, $rose(o_valid) |-> !$past(o_ready), "result presented without a transaction in progress")
    `VST_NEVER(a_drop_not_changed, i_clk, i_rst_n, o_valid && o_full_drop && (o_changed || o_found), "dropped add also reports found or changed")
    `VST_ASSERT(a_result_held, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_entry_count) && $stable(o_changed)), "stalled result changed")

endmodule

bind value_set_table vst_checker u_vst_checker (.*);
